>>> hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte-level functions of the AES-128 core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int NumKeys = NumRounds + 1;
  localparam int RoundW = 4;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] round;
  } kexp_status_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  localparam logic [7:0] RCON [NumKeys] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return x[7] ? ((x << 1) ^ 8'h1B) : (x << 1);
  endfunction

endpackage

>>> hw/rtl/aes_key_expand.sv
// ----------------------------------------------------------------------------
// AES key expansion
// Derives one round key per cycle and writes it to the round key store.
// ----------------------------------------------------------------------------
module aes_key_expand
  import aes_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [127:0]        key,
  output kexp_status_t        status,
  output logic                wr_en,
  output logic [RoundW-1:0]   wr_addr,
  output logic [127:0]        wr_data
);

  logic         busy;
  logic [3:0]   round;
  logic [127:0] prev;
  logic [31:0]  temp;
  logic [31:0]  w0, w1, w2, w3;

  always_comb begin
    temp = {FWD_SBOX[prev[23:16]] ^ RCON[round], FWD_SBOX[prev[15:8]],
            FWD_SBOX[prev[7:0]], FWD_SBOX[prev[31:24]]};
    w0 = prev[127:96] ^ temp;
    w1 = prev[95:64] ^ w0;
    w2 = prev[63:32] ^ w1;
    w3 = prev[31:0] ^ w2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      round <= '0;
    end else if (start) begin
      busy <= 1'b1;
      round <= '0;
    end else if (busy) begin
      round <= round + 4'd1;
      if (round == 4'(NumRounds)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) prev <= wr_data;
  end

  assign wr_en = busy && !start;
  assign wr_addr = round;
  assign wr_data = (round == '0) ? key : {w0, w1, w2, w3};
  assign status = '{busy: busy, round: round};

endmodule

>>> hw/rtl/aes_round.sv
// ----------------------------------------------------------------------------
// AES round unit
// One shared encrypt or decrypt round, used once per cycle by the sequencer unless a receiver stall holds it.
// ----------------------------------------------------------------------------
module aes_round
  import aes_pkg::*;
(
  input  logic         decrypt,
  input  logic         last,
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  output logic [127:0] state_out
);

  logic [7:0]   s  [16];
  logic [7:0]   o  [16];
  logic [7:0]   k  [16];
  logic [7:0]   m  [16];
  logic [7:0]   x2 [16];
  logic [7:0]   x4 [16];
  logic [7:0]   x8 [16];
  logic [127:0] flat;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (decrypt) begin
          o[((c + r) % 4) * 4 + r] = INV_SBOX[s[c*4+r]];
        end else begin
          o[c*4+r] = FWD_SBOX[s[((c + r) % 4) * 4 + r]];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      k[i] = decrypt ? (o[i] ^ round_key[127-8*i -: 8]) : o[i];
      x2[i] = xtime(k[i]);
      x4[i] = xtime(x2[i]);
      x8[i] = xtime(x4[i]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (decrypt) begin
          m[c*4+r] = (x8[c*4+r] ^ x4[c*4+r] ^ x2[c*4+r])
                   ^ (x8[c*4+(r+1)%4] ^ x2[c*4+(r+1)%4] ^ k[c*4+(r+1)%4])
                   ^ (x8[c*4+(r+2)%4] ^ x4[c*4+(r+2)%4] ^ k[c*4+(r+2)%4])
                   ^ (x8[c*4+(r+3)%4] ^ k[c*4+(r+3)%4]);
        end else begin
          m[c*4+r] = x2[c*4+r] ^ x2[c*4+(r+1)%4] ^ k[c*4+(r+1)%4]
                   ^ k[c*4+(r+2)%4] ^ k[c*4+(r+3)%4];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      flat[127-8*i -: 8] = last ? k[i] : m[i];
    end
    state_out = decrypt ? flat : (flat ^ round_key);
  end

endmodule

>>> hw/rtl/aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Round-iterative AES-128 ECB core with an APB key port.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, in_data) carries one transfer per
// block: the kind bit selects encryption or decryption. The output channel
// (out_valid, out_ready, out_data) returns one transfer per block.
// The key is written through APB as key_high at 0x0 and key_low at 0x8.
// Every key write, and reset itself, starts an expansion of the 11 round
// keys into the key store, one key per cycle; no block is accepted meanwhile.
// A block passes through the core in order: the first key addition, then
// each round through the single shared round unit, the key store being read
// in the cycle before each key is used. The result then sits in the output
// register, and a new block is accepted only after the previous result is in it.
// A receiver stall holds the result in the output register. One more block
// may be accepted meanwhile; it waits in its last round, with in_ready low,
// until the output register is free again.
// ----------------------------------------------------------------------------
module aes128_block_cipher
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;

  logic [1:0]        state;
  logic [63:0]       key_high;
  logic [63:0]       key_low;
  logic              cfg_write;
  logic              key_sel;
  logic              decrypt;
  logic [3:0]        round;
  logic [127:0]      data;
  logic [127:0]      rkey;
  logic [127:0]      round_out;
  logic [RoundW-1:0] rd_addr;
  logic [3:0]        round_next;
  logic              finish;
  kexp_status_t      kstat;
  logic              wr_en;
  logic [RoundW-1:0] wr_addr;
  logic [127:0]      wr_data;
  logic [127:0]      key_store [NumKeys];

  assign pready = 1'b1;
  assign key_sel = paddr[3];
  assign cfg_write = psel && penable && pwrite && (paddr[2:0] == 3'd0);
  assign prdata = (key_sel == REG_KEY_LOW) ? key_low : key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_write) begin
      if (key_sel == REG_KEY_HIGH) key_high <= pwdata;
      else key_low <= pwdata;
    end
  end

  aes_key_expand u_kexp (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_write),
    .key     ({key_high, key_low}),
    .status  (kstat),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    round_next = round + 4'd1;
    if (state == ST_IDLE) begin
      rd_addr = in_data.kind ? RoundW'(NumRounds) : '0;
    end else if (round == 4'(NumRounds)) begin
      rd_addr = decrypt ? '0 : RoundW'(NumRounds);
    end else begin
      rd_addr = decrypt ? RoundW'(4'(NumRounds) - round_next) : round_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) key_store[wr_addr] <= wr_data;
    rkey <= key_store[rd_addr];
  end

  aes_round u_round (
    .decrypt   (decrypt),
    .last      (round == 4'(NumRounds)),
    .state_in  (data),
    .round_key (rkey),
    .state_out (round_out)
  );

  assign in_ready = (state == ST_IDLE) && !kstat.busy;
  assign finish = (state == ST_RUN) && (round == 4'(NumRounds)) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      round <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state <= ST_RUN;
            round <= '0;
          end
        end
        ST_RUN: begin
          if (round == 4'(NumRounds)) begin
            if (finish) state <= ST_IDLE;
          end else begin
            round <= round_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid && in_ready) begin
      decrypt <= (in_data.kind == KIND_DECRYPT);
      data <= {in_data.block_high, in_data.block_low};
    end else if (state == ST_RUN && round != 4'(NumRounds)) begin
      if (round == '0) data <= data ^ rkey;
      else data <= round_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) out_data <= '{result_high: round_out[127:64], result_low: round_out[63:0]};
  end

endmodule

>>> hw/rtl/aes128_block_cipher_checker.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher checker
// Port-level properties of the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module aes128_block_cipher_checker
  import aes_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      psel,
  input logic      penable,
  input logic      pwrite,
  input logic      pready
);

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("core idle right after input transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_write_blocks: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> !in_ready)
    else $error("input ready during key expansion");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind aes128_block_cipher aes128_block_cipher_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready)
);

>>> test/aes128_block_cipher_tb.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Checks the encrypt and decrypt results of the core against a behavioral AES
// model under random key settings, random flow control, long receiver stalls
// and sender pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_block_cipher_tb;
  import aes_pkg::*;

  typedef logic [7:0] byte16_t [16];

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [7:0]  round_keys [NumKeys][16];
  out_item_t   pending_results [$];
  int          errors;
  int          cycles;
  int          next_gap;
  int          hold_cycles;
  bit          no_idle;

  aes128_block_cipher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc = acc ^ a;
      a = a[7] ? ((a << 1) ^ 8'h1B) : (a << 1);
    end
    return acc;
  endfunction

  function automatic void expand_round_keys();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] tmp;
    for (int i = 0; i < 8; i++) begin
      w[i] = key_high[63 - 8 * i -: 8];
      w[8 + i] = key_low[63 - 8 * i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = w[(i - 1) * 4 + j];
      if (i % 4 == 0) begin
        tmp = t[0];
        t[0] = FWD_SBOX[t[1]] ^ RCON[i / 4];
        t[1] = FWD_SBOX[t[2]];
        t[2] = FWD_SBOX[t[3]];
        t[3] = FWD_SBOX[tmp];
      end
      for (int j = 0; j < 4; j++) w[i * 4 + j] = w[(i - 4) * 4 + j] ^ t[j];
    end
    for (int k = 0; k < NumKeys; k++)
      for (int i = 0; i < 16; i++) round_keys[k][i] = w[k * 16 + i];
  endfunction

  function automatic byte16_t add_round_key(input byte16_t s, input int k);
    for (int i = 0; i < 16; i++) s[i] = s[i] ^ round_keys[k][i];
    return s;
  endfunction

  function automatic byte16_t sub_and_shift(input byte16_t s, input bit inverse);
    byte16_t o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inverse) o[((c + r) % 4) * 4 + r] = INV_SBOX[s[c * 4 + r]];
        else o[c * 4 + r] = FWD_SBOX[s[((c + r) % 4) * 4 + r]];
      end
    return o;
  endfunction

  function automatic byte16_t mix_columns(input byte16_t s, input bit inverse);
    logic [7:0] coef [4];
    logic [7:0] a [4];
    logic [7:0] v;
    if (inverse) coef = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
    else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[c * 4 + r];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v = v ^ gf_mult(coef[(k - r + 4) % 4], a[k]);
        s[c * 4 + r] = v;
      end
    end
    return s;
  endfunction

  function automatic out_item_t aes_transform(input in_item_t item);
    byte16_t   s;
    out_item_t res;
    for (int i = 0; i < 8; i++) begin
      s[i] = item.block_high[63 - 8 * i -: 8];
      s[8 + i] = item.block_low[63 - 8 * i -: 8];
    end
    if (item.kind == KIND_ENCRYPT) begin
      s = add_round_key(s, 0);
      for (int rnd = 1; rnd < NumRounds; rnd++) begin
        s = mix_columns(sub_and_shift(s, 1'b0), 1'b0);
        s = add_round_key(s, rnd);
      end
      s = add_round_key(sub_and_shift(s, 1'b0), NumRounds);
    end else begin
      s = add_round_key(s, NumRounds);
      for (int rnd = NumRounds - 1; rnd >= 1; rnd--) begin
        s = add_round_key(sub_and_shift(s, 1'b1), rnd);
        s = mix_columns(s, 1'b1);
      end
      s = add_round_key(sub_and_shift(s, 1'b1), 0);
    end
    for (int i = 0; i < 8; i++) begin
      res.result_high[63 - 8 * i -: 8] = s[i];
      res.result_low[63 - 8 * i -: 8] = s[8 + i];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    errors++;
  endtask

  task automatic write_key(input logic [0:0] index, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (index == REG_KEY_HIGH) key_high = value;
    else key_low = value;
    expand_round_keys();
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    write_key(REG_KEY_HIGH, hi);
    write_key(REG_KEY_LOW, lo);
  endtask

  task automatic send_block(input logic kind, input logic [63:0] hi, input logic [63:0] lo);
    in_item_t item;
    item.kind = kind;
    item.block_high = hi;
    item.block_low = lo;
    if (next_gap > 0) begin
      in_valid <= 1'b0;
      repeat (next_gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(aes_transform(item));
    next_gap = no_idle ? 0 : $urandom_range(0, 17);
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    next_gap = 0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic send_random(input int count, input bit round_trip);
    logic [63:0] hi;
    logic [63:0] lo;
    logic        kind;
    out_item_t   cipher;
    in_item_t    plain;
    for (int n = 0; n < count; n++) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      kind = 1'($urandom_range(0, 1));
      send_block(kind, hi, lo);
      if (round_trip) begin
        plain.kind = kind;
        plain.block_high = hi;
        plain.block_low = lo;
        cipher = aes_transform(plain);
        send_block(~kind, cipher.result_high, cipher.result_low);
        n++;
      end
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.result_high, 64'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_high !== want.result_high)
          report_mismatch("result_high", out_data.result_high, want.result_high);
        if (out_data.result_low !== want.result_low)
          report_mismatch("result_low", out_data.result_low, want.result_low);
      end
    end
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && hold_cycles == 0);
    end
  end

  task automatic test_zero_key();
    send_block(KIND_ENCRYPT, 64'h0, 64'h0);
    send_block(KIND_DECRYPT, 64'h0, 64'h0);
    send_block(KIND_ENCRYPT, '1, '1);
    send_block(KIND_DECRYPT, '1, '1);
    send_block(KIND_ENCRYPT, 64'h8000000000000000, 64'h1);
    send_block(KIND_DECRYPT, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    drain();
  endtask

  task automatic test_standard_vector();
    in_item_t item;
    out_item_t res;
    set_key(64'h0001020304050607, 64'h08090A0B0C0D0E0F);
    item = '{KIND_ENCRYPT, 64'h0011223344556677, 64'h8899AABBCCDDEEFF};
    res = aes_transform(item);
    if (res.result_high !== 64'h69C4E0D86A7B0430)
      report_mismatch("model vector high", res.result_high, 64'h69C4E0D86A7B0430);
    if (res.result_low !== 64'hD8CDB78070B4C55A)
      report_mismatch("model vector low", res.result_low, 64'hD8CDB78070B4C55A);
    send_block(KIND_ENCRYPT, item.block_high, item.block_low);
    send_block(KIND_DECRYPT, res.result_high, res.result_low);
    drain();
  endtask

  task automatic test_key_extremes();
    set_key('1, '1);
    send_block(KIND_ENCRYPT, 64'h0, 64'h0);
    send_block(KIND_DECRYPT, '1, '1);
    send_random(4, 1'b0);
    drain();
    set_key(64'h0, '1);
    send_random(4, 1'b0);
    drain();
    write_key(REG_KEY_HIGH, '1);
    send_random(3, 1'b0);
    drain();
  endtask

  task automatic test_random_keys();
    for (int phase = 0; phase < 6; phase++) begin
      no_idle = (phase % 3 == 2);
      set_key({$urandom, $urandom}, {$urandom, $urandom});
      send_random(60, 1'b1);
      send_random(50, 1'b0);
      drain();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    set_key({$urandom, $urandom}, {$urandom, $urandom});
    hold_cycles = 400;
    no_idle = 1'b1;
    send_random(20, 1'b0);
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_sender_pause();
    send_random(15, 1'b1);
    drain();
    send_random(15, 1'b0);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    next_gap = 0;
    hold_cycles = 0;
    no_idle = 1'b0;
    key_high = '0;
    key_low = '0;
    expand_round_keys();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_key();
    test_standard_vector();
    test_key_extremes();
    test_random_keys();
    test_output_backpressure();
    test_sender_pause();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
